// ===== sv/cts_pkg.sv =====
// Package for the C-like token scanner: token kind codes, result item type,
// keyword table and character class helpers. No dependencies.
package cts_pkg;

  localparam int NAME_CHARS = 8;
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);
  localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;

  localparam logic [4:0] K_INT     = 5'd0;
  localparam logic [4:0] K_IDENT   = 5'd1;
  localparam logic [4:0] K_NUMBER  = 5'd2;
  localparam logic [4:0] K_COLON   = 5'd3;
  localparam logic [4:0] K_SEMI    = 5'd4;
  localparam logic [4:0] K_LPAREN  = 5'd5;
  localparam logic [4:0] K_RPAREN  = 5'd6;
  localparam logic [4:0] K_LBRACE  = 5'd7;
  localparam logic [4:0] K_RBRACE  = 5'd8;
  localparam logic [4:0] K_ASSIGN  = 5'd9;
  localparam logic [4:0] K_PLUS    = 5'd10;
  localparam logic [4:0] K_MINUS   = 5'd11;
  localparam logic [4:0] K_STAR    = 5'd12;
  localparam logic [4:0] K_SLASH   = 5'd13;
  localparam logic [4:0] K_PERCENT = 5'd14;
  localparam logic [4:0] K_EQ      = 5'd15;
  localparam logic [4:0] K_NE      = 5'd16;
  localparam logic [4:0] K_GT      = 5'd17;
  localparam logic [4:0] K_GE      = 5'd18;
  localparam logic [4:0] K_LT      = 5'd19;
  localparam logic [4:0] K_LE      = 5'd20;
  localparam logic [4:0] K_AMP     = 5'd21;
  localparam logic [4:0] K_PIPE    = 5'd22;
  localparam logic [4:0] K_BANG    = 5'd23;
  localparam logic [4:0] K_IF      = 5'd24;
  localparam logic [4:0] K_ELSE    = 5'd25;
  localparam logic [4:0] K_WHILE   = 5'd26;
  localparam logic [4:0] K_PRINT   = 5'd27;
  localparam logic [4:0] K_COMMENT = 5'd28;
  localparam logic [4:0] K_END     = 5'd29;
  localparam logic [4:0] K_ERROR   = 5'd30;

  typedef struct packed {
    logic [4:0]  kind;
    logic [63:0] value;
    logic [3:0]  len;
    logic        last;
  } token_t;

  typedef struct packed {
    logic [63:0] chars;
    logic [3:0]  len;
    logic [4:0]  kind;
  } kw_t;

  localparam int NUM_KW = 5;

  // characters packed first-in-low-byte
  localparam kw_t KW_TABLE [NUM_KW] = '{
    '{chars: 64'h0000_0000_0074_6E69, len: 4'd3, kind: K_INT},
    '{chars: 64'h0000_0000_0000_6669, len: 4'd2, kind: K_IF},
    '{chars: 64'h0000_0000_6573_6C65, len: 4'd4, kind: K_ELSE},
    '{chars: 64'h0000_0065_6C69_6877, len: 4'd5, kind: K_WHILE},
    '{chars: 64'h0000_0074_6E69_7270, len: 4'd5, kind: K_PRINT}
  };

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || (c == 8'h5F);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

endpackage

// ===== sv/c_like_token_scanner.sv =====
// Top level of the C-like token scanner: byte stream in, token items out.
// Depends on cts_pkg.
//
// One source byte is accepted per cycle while in_ready is high and is held
// back one item as lookahead; the held byte is scanned against the new byte
// by combinational compare and accumulate logic, and its token (if any) is
// pushed into a four-entry result queue. A zero byte also pushes the end token
// and returns the scanner to its reset state, so that item can produce two
// results. in_ready is high while the queue has room for two results, so with
// out_ready held high the block takes a byte every cycle; the only limit
// is the one-result-per-cycle queue read port.
module c_like_token_scanner import cts_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_source_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  out_token_kind,
  output logic [63:0] out_token_value,
  output logic [3:0]  out_name_length,
  output logic        out_last
);

  // scanner state
  logic [7:0]  held_byte_r, held_byte_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic        skip_r, skip_nxt;
  logic [63:0] word_chars_r, word_chars_nxt;
  logic [3:0]  word_cnt_r, word_cnt_nxt;
  logic        word_ovf_r, word_ovf_nxt;
  logic [30:0] num_r, num_nxt;

  // result queue
  token_t           q_r [Q_DEPTH];
  logic [Q_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]    cnt_r, cnt_nxt;

  logic        in_acc, pop;
  logic        tok_vld, end_vld;
  token_t      tok, end_tok, slot0;
  logic [1:0]  push_n;
  logic [34:0] num_mul;
  logic [30:0] num_sat;
  logic        kw_hit;
  logic [4:0]  kw_kind;

  assign in_ready = (cnt_r <= (Q_AW+1)'(Q_DEPTH - 2));
  assign in_acc   = in_valid && in_ready;
  assign out_valid = (cnt_r != '0);
  assign pop      = out_valid && out_ready;

  assign out_token_kind  = q_r[rd_ptr_r].kind;
  assign out_token_value = q_r[rd_ptr_r].value;
  assign out_name_length = q_r[rd_ptr_r].len;
  assign out_last        = q_r[rd_ptr_r].last;

  // x*10 + digit, then clamp
  assign num_mul = ({4'd0, num_r} << 3) + ({4'd0, num_r} << 1)
                 + {31'd0, held_byte_r[3:0] - 4'd0};
  assign num_sat = (num_mul > {4'd0, NUM_MAX}) ? NUM_MAX : num_mul[30:0];

  assign end_tok = '{kind: K_END, value: 64'd0, len: 4'd0, last: 1'b1};

  always_comb begin
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;
    skip_nxt       = skip_r;
    word_chars_nxt = word_chars_r;
    word_cnt_nxt   = word_cnt_r;
    word_ovf_nxt   = word_ovf_r;
    num_nxt        = num_r;
    tok_vld        = 1'b0;
    tok            = '{kind: K_ERROR, value: 64'd0, len: 4'd0, last: 1'b0};
    end_vld        = 1'b0;
    kw_hit         = 1'b0;
    kw_kind        = K_IDENT;

    if (in_acc) begin
      skip_nxt = 1'b0;
      if (held_valid_r && !skip_r) begin
        if (is_word(held_byte_r)) begin
          if (word_cnt_r < 4'(NAME_CHARS)) begin
            for (int i = 0; i < 8; i++) begin
              if (word_cnt_r[2:0] == 3'(i)) word_chars_nxt[8*i +: 8] = held_byte_r;
            end
            word_cnt_nxt = word_cnt_r + 4'd1;
          end else begin
            word_ovf_nxt = 1'b1;
          end
          if (!is_word(in_source_byte)) begin
            for (int k = NUM_KW - 1; k >= 0; k--) begin
              if (KW_TABLE[k].len == word_cnt_nxt && KW_TABLE[k].chars == word_chars_nxt) begin
                kw_hit  = 1'b1;
                kw_kind = KW_TABLE[k].kind;
              end
            end
            tok_vld = 1'b1;
            if (word_ovf_nxt) begin
              tok.kind = K_ERROR;
            end else if (kw_hit) begin
              tok.kind = kw_kind;
            end else begin
              tok.kind  = K_IDENT;
              tok.value = word_chars_nxt;
              tok.len   = word_cnt_nxt;
            end
            word_chars_nxt = 64'd0;
            word_cnt_nxt   = 4'd0;
            word_ovf_nxt   = 1'b0;
          end
        end else if (is_digit(held_byte_r)) begin
          num_nxt = num_sat;
          if (!is_digit(in_source_byte)) begin
            tok_vld   = 1'b1;
            tok.kind  = K_NUMBER;
            tok.value = {33'd0, num_sat};
            num_nxt   = 31'd0;
          end
        end else begin
          tok_vld = 1'b1;
          case (held_byte_r)
            8'h3A: tok.kind = K_COLON;
            8'h3B: tok.kind = K_SEMI;
            8'h28: tok.kind = K_LPAREN;
            8'h29: tok.kind = K_RPAREN;
            8'h7B: tok.kind = K_LBRACE;
            8'h7D: tok.kind = K_RBRACE;
            8'h2B: tok.kind = K_PLUS;
            8'h2D: tok.kind = K_MINUS;
            8'h2A: tok.kind = K_STAR;
            8'h25: tok.kind = K_PERCENT;
            8'h26: tok.kind = K_AMP;
            8'h7C: tok.kind = K_PIPE;
            8'h3D: begin
              skip_nxt = (in_source_byte == 8'h3D);
              tok.kind = skip_nxt ? K_EQ : K_ASSIGN;
            end
            8'h2F: begin
              skip_nxt = (in_source_byte == 8'h2F);
              tok.kind = skip_nxt ? K_COMMENT : K_SLASH;
            end
            8'h21: begin
              skip_nxt = (in_source_byte == 8'h3D);
              tok.kind = skip_nxt ? K_NE : K_BANG;
            end
            8'h3E: begin
              skip_nxt = (in_source_byte == 8'h3D);
              tok.kind = skip_nxt ? K_GE : K_GT;
            end
            8'h3C: begin
              skip_nxt = (in_source_byte == 8'h3D);
              tok.kind = skip_nxt ? K_LE : K_LT;
            end
            default: tok_vld = 1'b0;
          endcase
        end
      end

      if (in_source_byte == 8'h00) begin
        // end of stream: flush token above, then back to reset state
        end_vld        = 1'b1;
        held_byte_nxt  = 8'h00;
        held_valid_nxt = 1'b0;
        skip_nxt       = 1'b0;
        word_chars_nxt = 64'd0;
        word_cnt_nxt   = 4'd0;
        word_ovf_nxt   = 1'b0;
        num_nxt        = 31'd0;
      end else begin
        held_byte_nxt  = in_source_byte;
        held_valid_nxt = 1'b1;
      end
    end
  end

  assign push_n = {1'b0, tok_vld} + {1'b0, end_vld};
  assign slot0  = tok_vld ? tok : end_tok;

  assign wr_ptr_nxt = wr_ptr_r + Q_AW'(push_n);
  assign rd_ptr_nxt = rd_ptr_r + Q_AW'(pop);
  assign cnt_nxt    = cnt_r + (Q_AW+1)'(push_n) - (Q_AW+1)'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_byte_r  <= 8'h00;
      held_valid_r <= 1'b0;
      skip_r       <= 1'b0;
      word_chars_r <= 64'd0;
      word_cnt_r   <= 4'd0;
      word_ovf_r   <= 1'b0;
      num_r        <= 31'd0;
      wr_ptr_r     <= '0;
      rd_ptr_r     <= '0;
      cnt_r        <= '0;
    end else begin
      held_byte_r  <= held_byte_nxt;
      held_valid_r <= held_valid_nxt;
      skip_r       <= skip_nxt;
      word_chars_r <= word_chars_nxt;
      word_cnt_r   <= word_cnt_nxt;
      word_ovf_r   <= word_ovf_nxt;
      num_r        <= num_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      rd_ptr_r     <= rd_ptr_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) q_r[wr_ptr_r] <= slot0;
    if (push_n == 2'd2) q_r[wr_ptr_r + Q_AW'(1)] <= end_tok;
  end

  // queue never overfills
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (Q_AW+1)'(Q_DEPTH))
    else $error("result queue overflow");

  // end of stream clears the lookahead and word state
  a_eos_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_source_byte == 8'h00) |=>
      (!held_valid_r && word_cnt_r == 4'd0 && num_r == 31'd0))
    else $error("state not cleared after end of stream");

  // a nonzero byte becomes the lookahead
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_source_byte != 8'h00) |=>
      (held_valid_r && held_byte_r == $past(in_source_byte)))
    else $error("lookahead byte not captured");

  // last flag only on end tokens
  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_token_kind == K_END))
    else $error("last flag on non-end token");

endmodule
